// ----- hdl/norle_pkg.sv -----
package norle_pkg;

  // Widths of the stream fields and of the job bookkeeping
  localparam int unsigned ByteBits       = 8;
  localparam int unsigned CountBits      = 20;
  localparam int unsigned CfgBits        = 24;
  localparam int unsigned OutputSizeBits = 24;
  localparam int unsigned ApbDataBits    = 32;
  localparam int unsigned ApbAddrBits    = 3;

  // Token queue between parser and executor
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned QueuePtrBits   = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits   = $clog2(QueueDepth + 1);

  // Register index of output_size
  localparam logic RegOutputSize = 1'b0;

  // Opcode high nibble: family in bits 3:2, count size in bits 1:0
  localparam logic [1:0] FamLiteral = 2'd0;
  localparam logic [1:0] FamBad     = 2'd1;
  localparam logic [1:0] FamRepeat  = 2'd2;
  localparam logic [1:0] FamZero    = 2'd3;
  localparam logic [1:0] SizeBad    = 2'd3;

  typedef enum logic [1:0] {
    STATUS_COMPLETE = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_TRUNC    = 2'd2,
    STATUS_BAD      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TOK_NONE = 2'd0,
    TOK_RUN  = 2'd1,
    TOK_LIT  = 2'd2,
    TOK_BAD  = 2'd3
  } tok_kind_e;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_OPCODE  = 4'b0001,
    PH_OPERAND = 4'b0010,
    PH_LITERAL = 4'b0100,
    PH_BAD     = 4'b1000
  } phase_e;

  // One classified input item, as handed from parser to executor
  typedef struct packed {
    tok_kind_e              kind;
    logic                   is_literal;  // run header of a literal block
    logic [ByteBits-1:0]    value;
    logic [CountBits-1:0]   count;
    logic                   last;
    logic                   in_operand;  // parser still inside operand bytes
  } token_t;

endpackage

// ----- hdl/norle_front.sv -----
module norle_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [norle_pkg::ByteBits-1:0] raw_byte_i,
  input  logic                          last_byte_i,
  input  logic                          take_i,
  output norle_pkg::token_t             tok_o
);

  norle_pkg::phase_e                     phase_q, phase_d;
  logic [3:0]                            op_q, op_d;
  logic [1:0]                            opl_q, opl_d;
  logic [norle_pkg::ByteBits-1:0]        fill_q, fill_d;
  logic [norle_pkg::CountBits-1:0]       acc_q, acc_d;
  logic [norle_pkg::CountBits-1:0]       lit_q, lit_d;
  logic                                  complete;
  logic [1:0]                            fam_in, size_in, fam_q, size_q, fam_d;
  norle_pkg::token_t                     tok;

  assign fam_in  = raw_byte_i[7:6];
  assign size_in = raw_byte_i[5:4];
  assign fam_q   = op_q[3:2];
  assign size_q  = op_q[1:0];
  assign fam_d   = op_d[3:2];

  // Syntactic parse of the byte stream; output budget is the executor's job
  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    opl_d    = opl_q;
    fill_d   = fill_q;
    acc_d    = acc_q;
    lit_d    = lit_q;
    complete = 1'b0;
    tok      = '0;
    tok.kind = norle_pkg::TOK_NONE;
    tok.last = last_byte_i;

    unique case (phase_q)
      norle_pkg::PH_OPCODE: begin
        op_d  = raw_byte_i[7:4];
        acc_d = norle_pkg::CountBits'(raw_byte_i[3:0]);
        if (size_in == norle_pkg::SizeBad || fam_in == norle_pkg::FamBad) begin
          phase_d  = norle_pkg::PH_BAD;
          tok.kind = norle_pkg::TOK_BAD;
        end else begin
          opl_d = size_in + {1'b0, (fam_in == norle_pkg::FamRepeat)};
          if (opl_d == 2'd0) begin
            complete = 1'b1;
          end else begin
            phase_d = norle_pkg::PH_OPERAND;
          end
        end
      end
      norle_pkg::PH_OPERAND: begin
        // repeat opcodes carry the fill byte ahead of the count bytes
        if (fam_q == norle_pkg::FamRepeat && opl_q == size_q + 2'd1) begin
          fill_d = raw_byte_i;
        end else begin
          acc_d = {acc_q[norle_pkg::CountBits-norle_pkg::ByteBits-1:0], raw_byte_i};
        end
        opl_d = opl_q - 2'd1;
        if (opl_d == 2'd0) begin
          complete = 1'b1;
        end
      end
      norle_pkg::PH_LITERAL: begin
        tok.kind  = norle_pkg::TOK_LIT;
        tok.value = raw_byte_i;
        tok.count = norle_pkg::CountBits'(1);
        lit_d     = lit_q - norle_pkg::CountBits'(1);
        if (lit_d == '0) begin
          phase_d = norle_pkg::PH_OPCODE;
        end
      end
      norle_pkg::PH_BAD: begin
      end
      default: begin
      end
    endcase

    // Instruction fully known: hand over the run
    if (complete) begin
      tok.kind       = norle_pkg::TOK_RUN;
      tok.count      = acc_d;
      tok.is_literal = (fam_d == norle_pkg::FamLiteral);
      tok.value      = (fam_d == norle_pkg::FamRepeat) ? fill_d : '0;
      if (fam_d == norle_pkg::FamLiteral && acc_d != '0) begin
        lit_d   = acc_d;
        phase_d = norle_pkg::PH_LITERAL;
      end else begin
        phase_d = norle_pkg::PH_OPCODE;
      end
    end

    tok.in_operand = (phase_d == norle_pkg::PH_OPERAND);

    // a new job starts after the last byte
    if (last_byte_i) begin
      phase_d = norle_pkg::PH_OPCODE;
    end
  end

  assign tok_o = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= norle_pkg::PH_OPCODE;
    end else if (take_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      op_q   <= op_d;
      opl_q  <= opl_d;
      fill_q <= fill_d;
      acc_q  <= acc_d;
      lit_q  <= lit_d;
    end
  end

endmodule

// ----- hdl/norle_queue.sv -----
module norle_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  norle_pkg::token_t tok_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output norle_pkg::token_t head_o
);

  norle_pkg::token_t                   mem_q [norle_pkg::QueueDepth];
  logic [norle_pkg::QueuePtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [norle_pkg::QueueCntBits-1:0]  count_q, count_d;

  assign full_o       = (count_q == norle_pkg::QueueCntBits'(norle_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign count_d      = count_q + norle_pkg::QueueCntBits'(push_i)
                                - norle_pkg::QueueCntBits'(pop_i);

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + norle_pkg::QueuePtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + norle_pkg::QueuePtrBits'(1);
      end
      count_q <= count_d;
    end
  end

  // token storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

// ----- hdl/norle_back.sv -----
module norle_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [norle_pkg::CfgBits-1:0]        output_size_i,
  input  logic                                 head_valid_i,
  input  norle_pkg::token_t                    head_i,
  output logic                                 pop_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [norle_pkg::ByteBits-1:0]       run_value_o,
  output logic [norle_pkg::CountBits-1:0]      run_length_o,
  output logic                                 end_of_job_o,
  output logic [1:0]                           status_o
);

  logic                                    start_q;
  logic                                    fin_q, fin_cur, fin_d;
  norle_pkg::status_e                      fstat_q, fstat_cur, fstat_d, status_d;
  logic [norle_pkg::OutputSizeBits-1:0]    left_q, left_cur, left_d, count_ext;
  logic                                    emit_run, emit, load_ok, proc;
  logic [norle_pkg::ByteBits-1:0]          val_d;
  logic [norle_pkg::CountBits-1:0]         len_d;

  logic                                    out_valid_q;
  logic [norle_pkg::ByteBits-1:0]          value_q;
  logic [norle_pkg::CountBits-1:0]         length_q;
  logic                                    eoj_q;
  norle_pkg::status_e                      status_q;

  // First item of a job samples the output size
  assign left_cur  = start_q ? norle_pkg::OutputSizeBits'(output_size_i) : left_q;
  assign fin_cur   = start_q ? (left_cur == '0) : fin_q;
  assign fstat_cur = start_q ? norle_pkg::STATUS_COMPLETE : fstat_q;
  assign count_ext = norle_pkg::OutputSizeBits'(head_i.count);

  // Budget check and run emission
  always_comb begin
    fin_d    = fin_cur;
    fstat_d  = fstat_cur;
    left_d   = left_cur;
    emit_run = 1'b0;
    val_d    = '0;
    len_d    = '0;
    if (!fin_cur) begin
      case (head_i.kind)
        norle_pkg::TOK_RUN: begin
          if (count_ext > left_cur) begin
            fin_d   = 1'b1;
            fstat_d = norle_pkg::STATUS_SHORT;
          end else if (!head_i.is_literal) begin
            left_d = left_cur - count_ext;
            if (left_d == '0) begin
              fin_d   = 1'b1;
              fstat_d = norle_pkg::STATUS_COMPLETE;
            end
            if (head_i.count != '0) begin
              emit_run = 1'b1;
              val_d    = head_i.value;
              len_d    = head_i.count;
            end
          end
        end
        norle_pkg::TOK_LIT: begin
          emit_run = 1'b1;
          val_d    = head_i.value;
          len_d    = head_i.count;
          left_d   = left_cur - norle_pkg::OutputSizeBits'(1);
          if (left_d == '0) begin
            fin_d   = 1'b1;
            fstat_d = norle_pkg::STATUS_COMPLETE;
          end
        end
        norle_pkg::TOK_BAD: begin
          fin_d   = 1'b1;
          fstat_d = norle_pkg::STATUS_BAD;
        end
        default: begin
        end
      endcase
    end

    // status at the end of the job
    if (!head_i.last) begin
      status_d = norle_pkg::STATUS_COMPLETE;
    end else if (fin_d) begin
      status_d = fstat_d;
    end else if (head_i.in_operand) begin
      status_d = norle_pkg::STATUS_SHORT;
    end else begin
      status_d = norle_pkg::STATUS_TRUNC;
    end
  end

  assign emit    = emit_run | head_i.last;
  assign load_ok = !out_valid_q || out_ready_i;
  assign proc    = head_valid_i && (!emit || load_ok);
  assign pop_o   = proc;

  // job bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      fin_q   <= 1'b0;
      fstat_q <= norle_pkg::STATUS_COMPLETE;
      left_q  <= '0;
    end else if (proc) begin
      start_q <= head_i.last;
      fin_q   <= fin_d;
      fstat_q <= fstat_d;
      left_q  <= left_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      value_q  <= val_d;
      length_q <= len_d;
      eoj_q    <= head_i.last;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign run_value_o  = value_q;
  assign run_length_o = length_q;
  assign end_of_job_o = eoj_q;
  assign status_o     = status_q;

endmodule

// ----- hdl/nibble_opcode_rle_decoder.sv -----
// Run-length decoder for a nibble-opcode byte stream. One compressed byte is
// taken per cycle on in_valid_i/in_ready_o while the queue is not full; a
// parser classifies each byte (opcode, operand, literal) and passes one item
// into a two-entry queue, and an executor retires one queued item per cycle
// against the remaining output budget, so the sustained rate is one byte per
// cycle while the result side keeps up. A byte that produces a result is
// written into the queue and, once the executor takes it, loads the output
// register. Each result carries run_value and run_length
// (1 for a literal byte, 0 for a bare status); the last byte of a job always
// gives one result with end_of_job set and status 0 complete, 1 stopped short,
// 2 truncated or 3 unknown opcode. output_size (APB, address 0) is sampled by
// the first byte of each job and must only be written while the block is idle.
module nibble_opcode_rle_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // APB configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [norle_pkg::ApbAddrBits-1:0]    paddr,
  input  logic [norle_pkg::ApbDataBits-1:0]    pwdata,
  output logic [norle_pkg::ApbDataBits-1:0]    prdata,
  output logic                                 pready,
  // compressed stream
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [norle_pkg::ByteBits-1:0]       raw_byte_i,
  input  logic                                 last_byte_i,
  // runs
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [norle_pkg::ByteBits-1:0]       run_value_o,
  output logic [norle_pkg::CountBits-1:0]      run_length_o,
  output logic                                 end_of_job_o,
  output logic [1:0]                           status_o
);

  logic [norle_pkg::CfgBits-1:0] output_size_q;
  logic                          cfg_sel, cfg_wr;
  logic                          push, full, pop, head_valid;
  norle_pkg::token_t             tok, head;

  // Register file
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[norle_pkg::ApbAddrBits-1] == norle_pkg::RegOutputSize);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? norle_pkg::ApbDataBits'(output_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_size_q <= '0;
    end else if (cfg_wr) begin
      output_size_q <= pwdata[norle_pkg::CfgBits-1:0];
    end
  end

  // Front end
  assign in_ready_o = !full;
  assign push       = in_valid_i && in_ready_o;

  norle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .raw_byte_i  (raw_byte_i),
    .last_byte_i (last_byte_i),
    .take_i      (push),
    .tok_o       (tok)
  );

  norle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .tok_i        (tok),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back end
  norle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .output_size_i (output_size_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .run_value_o   (run_value_o),
    .run_length_o  (run_length_o),
    .end_of_job_o  (end_of_job_o),
    .status_o      (status_o)
  );

  // Status only accompanies the final item of a job
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_job_o |-> status_o == norle_pkg::STATUS_COMPLETE)
    else $error("status set on a result that does not end the job");

  // Only the final item of a job may be a bare status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_job_o |-> run_length_o != '0)
    else $error("zero-length run emitted mid-job");

  // A job that stopped short or hit a bad opcode never ends with a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_job_o &&
    (status_o == norle_pkg::STATUS_SHORT || status_o == norle_pkg::STATUS_BAD)
    |-> run_length_o == '0)
    else $error("run emitted together with an abort status");

  // The queue never takes an item while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("push into a full token queue");

endmodule

// ----- tb/nibble_opcode_rle_decoder_tb.sv -----
`timescale 1ns / 1ps

module nibble_opcode_rle_decoder_tb;
  import norle_pkg::*;

  // Count size field of an opcode
  localparam logic [1:0] SzSmall  = 2'd0;
  localparam logic [1:0] SzMedium = 2'd1;
  localparam logic [1:0] SzLarge  = 2'd2;

  localparam logic [ApbAddrBits-1:0] OutputSizeAddr = ApbAddrBits'(4 * RegOutputSize);
  localparam int unsigned TargetItems = 1350;

  // Decoder state as seen by the predictor
  typedef enum logic [2:0] {
    DS_NEW_JOB,
    DS_OPCODE,
    DS_OPERAND,
    DS_LITERAL,
    DS_FILLED,
    DS_HALTED,
    DS_BAD_OP
  } dec_state_e;

  typedef struct packed {
    logic [ByteBits-1:0]  value;
    logic [CountBits-1:0] length;
    logic                 end_of_job;
    status_e              status;
  } run_rec_t;

  typedef struct packed {
    logic [ByteBits-1:0] data;
    logic                last;
  } byte_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [ApbAddrBits-1:0] paddr   = '0;
  logic [ApbDataBits-1:0] pwdata  = '0;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [ByteBits-1:0]  raw_byte  = '0;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ByteBits-1:0]  run_value;
  logic [CountBits-1:0] run_length;
  logic                 end_of_job;
  logic [1:0]           status;

  nibble_opcode_rle_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .raw_byte_i   (raw_byte),
    .last_byte_i  (last_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .run_value_o  (run_value),
    .run_length_o (run_length),
    .end_of_job_o (end_of_job),
    .status_o     (status)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stimulus and expectation stores
  byte_item_t          pending_bytes[$];
  logic [ByteBits-1:0] job_bytes[$];
  run_rec_t            expected_runs[$];
  int unsigned         n_items    = 0;
  int unsigned         fail_count = 0;

  // Predictor state
  dec_state_e           dec_state       = DS_NEW_JOB;
  logic [3:0]           run_code        = '0;
  logic [ByteBits-1:0]  run_fill        = '0;
  logic [1:0]           operands_left   = '0;
  logic [CountBits-1:0] run_count       = '0;
  logic [CountBits-1:0] literal_left    = '0;
  logic [23:0]          output_left     = '0;
  logic [23:0]          cfg_output_size = '0;

  function automatic void settle_budget();
    if (output_left == 0) dec_state = DS_FILLED;
    else dec_state = DS_OPCODE;
  endfunction

  // Count is complete: check it against the budget and start or emit the run
  function automatic logic close_instruction(output logic [ByteBits-1:0] val,
                                             output logic [CountBits-1:0] len);
    logic [1:0] fam;
    fam = run_code[3:2];
    val = '0;
    len = '0;
    if (run_count > output_left) begin
      dec_state = DS_HALTED;
      return 1'b0;
    end
    if (fam == FamLiteral) begin
      if (run_count == 0) begin
        dec_state = DS_OPCODE;
      end else begin
        literal_left = run_count;
        dec_state    = DS_LITERAL;
      end
      return 1'b0;
    end
    output_left = output_left - 24'(run_count);
    settle_budget();
    if (run_count == 0) return 1'b0;
    val = (fam == FamZero) ? '0 : run_fill;
    len = run_count;
    return 1'b1;
  endfunction

  // Works out the result (if any) of one accepted byte
  function automatic void decode_step(input logic [ByteBits-1:0] b, input logic last);
    logic                 have;
    logic [1:0]           fam;
    logic [1:0]           sz;
    logic [ByteBits-1:0]  val;
    logic [CountBits-1:0] len;
    run_rec_t             r;
    have = 1'b0;
    val  = '0;
    len  = '0;
    if (dec_state == DS_NEW_JOB) begin
      output_left = cfg_output_size;
      settle_budget();
    end
    case (dec_state)
      DS_OPCODE: begin
        run_code  = b[7:4];
        run_count = CountBits'(b[3:0]);
        fam       = b[7:6];
        sz        = b[5:4];
        if (sz == SizeBad || fam == FamBad) begin
          dec_state = DS_BAD_OP;
        end else begin
          operands_left = sz + ((fam == FamRepeat) ? 2'd1 : 2'd0);
          if (operands_left == 0) have = close_instruction(val, len);
          else dec_state = DS_OPERAND;
        end
      end
      DS_OPERAND: begin
        fam = run_code[3:2];
        sz  = run_code[1:0];
        // repeat opcodes carry the fill byte ahead of the count bytes
        if (fam == FamRepeat && operands_left == sz + 2'd1) run_fill = b;
        else run_count = {run_count[11:0], b};
        operands_left = operands_left - 2'd1;
        if (operands_left == 0) have = close_instruction(val, len);
      end
      DS_LITERAL: begin
        have         = 1'b1;
        val          = b;
        len          = 1;
        literal_left = literal_left - 1'b1;
        output_left  = output_left - 1'b1;
        if (literal_left == 0) settle_budget();
      end
      default: ;
    endcase
    r.value      = val;
    r.length     = len;
    r.end_of_job = last;
    r.status     = STATUS_COMPLETE;
    if (last) begin
      case (dec_state)
        DS_FILLED:             r.status = STATUS_COMPLETE;
        DS_HALTED, DS_OPERAND: r.status = STATUS_SHORT;
        DS_BAD_OP:             r.status = STATUS_BAD;
        default:               r.status = STATUS_TRUNC;
      endcase
      have      = 1'b1;
      dec_state = DS_NEW_JOB;
    end
    if (have) expected_runs.push_back(r);
  endfunction

  // Moves the job bytes into the send queue, marking the final one
  task automatic flush_job();
    for (int i = 0; i < job_bytes.size(); i++) begin
      pending_bytes.push_back({job_bytes[i], 1'(i == job_bytes.size() - 1)});
    end
    n_items += job_bytes.size();
    job_bytes.delete();
  endtask

  // One job: mostly well-formed instructions within budget, sometimes broken
  task automatic build_job(input logic [23:0] size);
    logic [23:0]          remaining;
    logic [CountBits-1:0] cnt;
    logic [CountBits-1:0] cap;
    logic [1:0]           fam;
    logic [1:0]           sz;
    logic [1:0]           min_sz;
    logic [3:0]           nib;
    int unsigned          n_instr;
    int unsigned          cut;
    logic                 stop;
    remaining = size;
    stop      = 1'b0;
    n_instr   = 0;
    if ($urandom_range(0, 15) == 0) begin
      // noise
      repeat ($urandom_range(1, 8)) job_bytes.push_back(8'($urandom));
    end else begin
      while (remaining != 0 && !stop && n_instr < 24) begin
        n_instr++;
        cap = (remaining > 24'hFFFFF) ? 20'hFFFFF : remaining[19:0];
        case ($urandom_range(0, 2))
          0:       fam = FamLiteral;
          1:       fam = FamRepeat;
          default: fam = FamZero;
        endcase
        if ($urandom_range(0, 39) == 0) begin
          // unknown opcode
          if ($urandom_range(0, 1) == 1) nib = {FamBad, 2'($urandom)};
          else nib = {2'($urandom), SizeBad};
          job_bytes.push_back({nib, 4'($urandom)});
          stop = 1'b1;
        end else begin
          if (remaining < 24'hFFFFF && $urandom_range(0, 24) == 0) begin
            // count beyond the remaining output
            cnt  = CountBits'($urandom_range(remaining + 1, 20'hFFFFF));
            stop = 1'b1;
          end else if (fam == FamLiteral) begin
            cnt = CountBits'($urandom_range(0, (cap < 6) ? cap : 6));
          end else begin
            case ($urandom_range(0, 3))
              0:       cnt = cap;
              1:       cnt = CountBits'($urandom_range(0, (cap < 15) ? cap : 15));
              2:       cnt = CountBits'($urandom_range(0, (cap < 20'hFFF) ? cap : 20'hFFF));
              default: cnt = CountBits'($urandom_range(0, cap));
            endcase
          end
          min_sz = (cnt < 16) ? SzSmall : (cnt < 20'h1000) ? SzMedium : SzLarge;
          sz     = 2'($urandom_range(min_sz, SzLarge));
          nib    = (sz == SzSmall) ? cnt[3:0] : (sz == SzMedium) ? cnt[11:8] : cnt[19:16];
          job_bytes.push_back({fam, sz, nib});
          if (fam == FamRepeat) job_bytes.push_back(8'($urandom));
          if (sz == SzLarge) job_bytes.push_back(cnt[15:8]);
          if (sz != SzSmall) job_bytes.push_back(cnt[7:0]);
          if (!stop) begin
            if (fam == FamLiteral) repeat (cnt) job_bytes.push_back(8'($urandom));
            remaining = remaining - 24'(cnt);
          end
        end
      end
    end
    if (job_bytes.size() > 1 && $urandom_range(0, 7) == 0) begin
      // stream cut short
      cut = $urandom_range(1, job_bytes.size());
      while (job_bytes.size() > cut) void'(job_bytes.pop_back());
    end else if (job_bytes.size() == 0 || $urandom_range(0, 1) == 1) begin
      // trailing bytes that the decoder skips
      repeat ($urandom_range(1, 3)) job_bytes.push_back(8'($urandom));
    end
    flush_job();
  endtask

  task automatic write_output_size(input logic [23:0] sz);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OutputSizeAddr;
    pwdata  <= ApbDataBits'(sz);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_output_size = sz;
  endtask

  // Sampled on rising edges, where the send queue cannot change
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid || expected_runs.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Sender: bursts of items with random gaps between them
  logic        in_taken   = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    byte_item_t nxt;
    if (rst_ni && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        raw_byte  <= nxt.data;
        last_byte <= nxt.last;
        in_valid  <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternating open and stalled stretches
  int unsigned rdy_left = 0;

  always @(negedge clk_i) begin
    if (rdy_left != 0) begin
      rdy_left--;
    end else begin
      out_ready <= !out_ready;
      if (out_ready) rdy_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                                            : $urandom_range(1, 4);
      else rdy_left = $urandom_range(1, 40);
    end
  end

  // Monitor: predict on accepted input items, check accepted results
  always @(posedge clk_i) begin
    run_rec_t want;
    if (rst_ni && in_valid && in_ready) begin
      decode_step(raw_byte, last_byte);
      in_taken = 1'b1;
    end
    if (rst_ni && out_valid && out_ready) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected result: run_value %0h run_length %0d end_of_job %0d status %0d",
               run_value, run_length, end_of_job, status);
        fail_count++;
      end else begin
        want = expected_runs.pop_front();
        if (run_value !== want.value) begin
          $error("run_value: expected %0h, got %0h", want.value, run_value);
          fail_count++;
        end
        if (run_length !== want.length) begin
          $error("run_length: expected %0d, got %0d", want.length, run_length);
          fail_count++;
        end
        if (end_of_job !== want.end_of_job) begin
          $error("end_of_job: expected %0d, got %0d", want.end_of_job, end_of_job);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [23:0] sz_pick;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero output size: the byte is skipped
    write_output_size(24'd0);
    job_bytes = '{8'hFF};
    flush_job();
    wait_drained();

    // Largest output size, every opcode, run and status on the last item
    write_output_size(24'hFFFFFF);
    job_bytes = '{{FamZero, SzLarge, 4'hF}, 8'hFF, 8'hFF,
                  {FamRepeat, SzLarge, 4'h0}, 8'hFF, 8'h00, 8'h00,
                  {FamRepeat, SzMedium, 4'h1}, 8'h7E, 8'h00,
                  {FamZero, SzMedium, 4'h0}, 8'h05,
                  {FamRepeat, SzSmall, 4'h3}, 8'h55,
                  {FamZero, SzSmall, 4'h1},
                  {FamLiteral, SzLarge, 4'h0}, 8'h00, 8'h01, 8'h5A,
                  {FamLiteral, SzMedium, 4'h0}, 8'h01, 8'hA5,
                  {FamLiteral, SzSmall, 4'h1}, 8'hE7};
    flush_job();
    wait_drained();

    // Output filled, count too large, unknown opcode, operands cut off
    write_output_size(24'd3);
    job_bytes = '{{FamRepeat, SzSmall, 4'h3}, 8'h81, 8'h00};
    flush_job();
    job_bytes = '{{FamZero, SzSmall, 4'h4}};
    flush_job();
    job_bytes = '{{FamBad, SzSmall, 4'h0}};
    flush_job();
    job_bytes = '{{FamZero, SzMedium, 4'h0}};
    flush_job();
    wait_drained();

    // Random jobs over a spread of output sizes
    while (n_items < TargetItems) begin
      case ($urandom_range(0, 7))
        0: begin
          case ($urandom_range(0, 2))
            0:       sz_pick = 24'd0;
            1:       sz_pick = 24'd1;
            default: sz_pick = 24'hFFFFFF;
          endcase
        end
        1, 2, 3: sz_pick = 24'($urandom_range(1, 40));
        4, 5:    sz_pick = 24'($urandom_range(41, 600));
        6:       sz_pick = 24'($urandom_range(601, 20'hFFFFF));
        default: sz_pick = 24'($urandom_range(0, 24'hFFFFFF));
      endcase
      write_output_size(sz_pick);
      repeat ($urandom_range(3, 8)) build_job(sz_pick);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS nibble_opcode_rle_decoder");
    end else begin
      $display("FAIL nibble_opcode_rle_decoder");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAIL nibble_opcode_rle_decoder");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/norle_pkg.sv
hdl/norle_front.sv
hdl/norle_queue.sv
hdl/norle_back.sv
hdl/nibble_opcode_rle_decoder.sv
tb/nibble_opcode_rle_decoder_tb.sv
